>>> src/sro_pkg.sv
// Shared types, constants and helpers for the sequence reorder window.
// Used by every module of the block; depends on nothing.
package sro_pkg;

	localparam int DEPTH    = 16;
	localparam int TAG_BITS = 16;
	localparam int SEQ_W    = 32;
	localparam int TIME_W   = 16;
	localparam int PW       = $clog2(DEPTH);
	localparam int SW       = $clog2(DEPTH + 1);

	localparam logic [2:0] CAUSE_INORDER = 3'd0;
	localparam logic [2:0] CAUSE_OLD     = 3'd1;
	localparam logic [2:0] CAUSE_ADV     = 3'd2;
	localparam logic [2:0] CAUSE_FLUSH   = 3'd3;
	localparam logic [2:0] CAUSE_BYPASS  = 3'd4;

	localparam logic       OP_TICK = 1'b1;
	localparam logic [1:0] CLS_TCP = 2'd1;

	localparam logic [1:0] CFG_UDP_WIN = 2'd0;
	localparam logic [1:0] CFG_TCP_WIN = 2'd1;
	localparam logic [1:0] CFG_UDP_TMO = 2'd2;
	localparam logic [1:0] CFG_TCP_TMO = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DEC, ST_ADV, ST_INS, ST_REL, ST_UPD, ST_FCHK, ST_FLOOP, ST_FEND, ST_FIN
	} state_t;

	typedef struct packed {
		logic                set;
		logic                clr;
		logic                wipe;
		logic                wipe_win;
		logic [PW:0]         idx;
		logic [TAG_BITS-1:0] tag;
	} slot_cmd_t;

	typedef struct packed {
		logic                valid;
		logic [TAG_BITS-1:0] tag;
		logic [SEQ_W-1:0]    seq;
		logic                tcp;
		logic [2:0]          cause;
	} emit_t;

	typedef struct packed {
		logic can;
		logic pend;
	} obuf_stat_t;

	// window size in slots: 2^lg clipped to DEPTH, zero means bypass
	function automatic logic [SW-1:0] win_size(input logic [2:0] lg);
		int s;
		s = 1;
		for (int i = 0; i < 7; i++) begin
			if (i < int'(lg) && s * 2 <= DEPTH) s = s * 2;
		end
		if (lg == 3'd0) s = 0;
		return SW'(s);
	endfunction

endpackage

>>> src/sro_alu.sv
// Shared 32-bit adder used by the sequencer for every sequence and time sum.
// Depends on sro_pkg.
module sro_alu (
	input  logic [sro_pkg::SEQ_W-1:0] a,
	input  logic [sro_pkg::SEQ_W-1:0] b,
	input  logic                      cin,
	output logic [sro_pkg::SEQ_W-1:0] sum
);
	assign sum = a + b + {{(sro_pkg::SEQ_W-1){1'b0}}, cin};
endmodule

>>> src/sro_slots.sv
// Slot store of both rings: valid flags in flops, tags in a plain array.
// Depends on sro_pkg.
module sro_slots (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sro_pkg::slot_cmd_t           cmd,
	input  logic [sro_pkg::PW:0]         rd_idx,
	output logic                         rd_valid,
	output logic [sro_pkg::TAG_BITS-1:0] rd_tag
);
	logic [2*sro_pkg::DEPTH-1:0] valid_q;
	logic [sro_pkg::TAG_BITS-1:0] tag_q [2*sro_pkg::DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.wipe) begin
			valid_q[cmd.wipe_win*sro_pkg::DEPTH +: sro_pkg::DEPTH] <= '0;
		end else if (cmd.set) begin
			valid_q[cmd.idx] <= 1'b1;
		end else if (cmd.clr) begin
			valid_q[cmd.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set) tag_q[cmd.idx] <= cmd.tag;
	end

	assign rd_valid = valid_q[rd_idx];
	assign rd_tag   = tag_q[rd_idx];
endmodule

>>> src/sro_outbuf.sv
// Result staging: one pending beat held until the next (to set tlast), then
// the output register. Depends on sro_pkg.
module sro_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sro_pkg::emit_t        emit,
	input  logic                  fin,
	output sro_pkg::obuf_stat_t   stat,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,  // packet_tag_res[15:0], seq_out[47:16]
	output logic [3:0]            m_tuser,  // from_tcp[0], release_cause[3:1]
	output logic                  m_tlast
);
	logic           pend_q;
	sro_pkg::emit_t pd_q;
	logic           out_q;
	logic           last_q;
	logic [47:0]    data_q;
	logic [3:0]     user_q;
	logic           out_free, can, push, fin_go, load;

	assign out_free = !out_q || m_tready;
	assign can      = !pend_q || out_free;
	assign push     = emit.valid && can;
	assign fin_go   = fin && can;
	assign load     = (push || fin_go) && pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			out_q  <= 1'b0;
		end else begin
			if (load) out_q <= 1'b1;
			else if (m_tready) out_q <= 1'b0;
			if (push) pend_q <= 1'b1;
			else if (fin_go) pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) pd_q <= emit;
		if (load) begin
			data_q <= {pd_q.seq, pd_q.tag};
			user_q <= {pd_q.cause, pd_q.tcp};
			last_q <= fin_go;
		end
	end

	assign stat.can  = can;
	assign stat.pend = pend_q;
	assign m_tvalid  = out_q;
	assign m_tdata   = data_q;
	assign m_tuser   = user_q;
	assign m_tlast   = last_q;
endmodule

>>> src/seq_reorder_window.sv
// Top level of the sequence reorder window: sequencer, window state, config.
// Depends on sro_pkg, sro_alu, sro_slots and sro_outbuf.
//
// Input beats on s_t* carry an insert (a packet tag at a sequence number) or
// a timeout tick. Two rings of up to 16 slots (UDP and TCP) hold packets that
// arrived ahead of the expected number. Released packets leave on m_t* one per
// beat; m_tlast marks the final release of an input beat, and a beat that
// releases nothing produces no output.
// s_tready is high only while the sequencer is idle. A bypass passes decode and
// finish; a too-old packet adds update; an insert adds an advance step per slot
// passed over when it lands far ahead (up to the window size), insert, and a
// release step per in-order packet at the ring start; a tick walks each flushed
// window up to its last held packet. All sequence and time sums go through one
// shared 32-bit adder, one per cycle. A window's size write empties that ring at
// once; writes must land only while idle, which the block does not enforce.
// After reset both rings are empty, disabled (bypass) and timers disarmed. When
// m_tready is low, one finished beat waits in the output register and one more
// in the pending stage; the sequencer then stalls until space frees.
module seq_reorder_window (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // seq_num[31:0], packet_tag[47:32], now_ms[63:48]
	input  logic [2:0]  s_tuser,   // operation[0], flow_class[2:1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // packet_tag_res[15:0], seq_out[47:16]
	output logic [3:0]  m_tuser,   // from_tcp[0], release_cause[3:1]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [15:0] cfg_data
);
	localparam int PW = sro_pkg::PW;
	localparam int SW = sro_pkg::SW;

	sro_pkg::state_t state_q, state_d;

	logic [2:0]                     lg_q   [2];
	logic [sro_pkg::TIME_W-1:0]     tmo_q  [2];
	logic [sro_pkg::SEQ_W-1:0]      exp_q  [2];
	logic [PW-1:0]                  ws_q   [2];
	logic [SW-1:0]                  held_q [2];
	logic                           armed_q[2];
	logic [sro_pkg::TIME_W-1:0]     stamp_q[2];

	logic                           op_q;
	logic [1:0]                     cls_q;
	logic [sro_pkg::SEQ_W-1:0]      seq_q;
	logic [sro_pkg::TAG_BITS-1:0]   tag_q;
	logic [sro_pkg::TIME_W-1:0]     now_q;
	logic                           w_q;
	logic                           cap_q;
	logic                           was_empty_q;
	logic                           rel_q;
	logic [SW-1:0]                  cnt_q;
	logic [sro_pkg::SEQ_W-1:0]      adv_seq_q;
	logic [sro_pkg::SEQ_W-1:0]      last_seq_q;

	logic [sro_pkg::SEQ_W-1:0]      alu_a, alu_b, sum;
	logic                           alu_cin;
	sro_pkg::slot_cmd_t             cmd;
	sro_pkg::emit_t                 emit;
	sro_pkg::obuf_stat_t            stat;
	logic                           fin, go;
	logic [PW-1:0]                  rd_pos;
	logic                           rd_valid;
	logic [sro_pkg::TAG_BITS-1:0]   rd_tag;

	logic [SW-1:0]                  sz;
	logic [PW-1:0]                  msk, ws, pos_ins, pos_fl, ws_inc;
	logic                           bypass, far, cap, fire, fl_done, cfg_wipe;
	logic [SW:0]                    steps_w;
	logic [SW-1:0]                  steps, k_inc;

	sro_alu u_alu (.a(alu_a), .b(alu_b), .cin(alu_cin), .sum(sum));

	sro_slots u_slots (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.rd_idx({w_q, rd_pos}), .rd_valid(rd_valid), .rd_tag(rd_tag)
	);

	sro_outbuf u_obuf (
		.clk(clk), .arst_n(arst_n), .emit(emit), .fin(fin), .stat(stat),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	assign s_tready = (state_q == sro_pkg::ST_IDLE);
	assign cfg_wipe = cfg_we && (cfg_idx == sro_pkg::CFG_UDP_WIN ||
	                             cfg_idx == sro_pkg::CFG_TCP_WIN);

	assign sz      = sro_pkg::win_size(lg_q[w_q]);
	assign msk     = PW'(sz - SW'(1));
	assign ws      = ws_q[w_q];
	assign ws_inc  = (ws + PW'(1)) & msk;
	assign pos_ins = (ws + sum[PW-1:0]) & msk;
	assign pos_fl  = (ws + cnt_q[PW-1:0]) & msk;
	assign k_inc   = cnt_q + SW'(1);
	assign bypass  = cls_q[1] || sz == '0;
	// sum holds the distance in the decode state
	assign far     = (|sum[sro_pkg::SEQ_W-1:SW]) || sum[SW-1:0] >= sz;
	assign cap     = (|sum[sro_pkg::SEQ_W-1:SW+1]) || sum[SW:0] >= {sz, 1'b0};
	assign steps_w = sum[SW:0] - {1'b0, sz} + (SW+1)'(1);
	assign steps   = cap ? sz : steps_w[SW-1:0];
	assign fire    = held_q[w_q] != '0 && tmo_q[w_q] != '0 &&
	                 (!armed_q[w_q] || sum[sro_pkg::TIME_W-1:0] >= tmo_q[w_q]);
	assign fl_done = k_inc == sz || (rd_valid && held_q[w_q] == SW'(1));

	// datapath control
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_cin = 1'b0;
		rd_pos  = ws;
		fin     = 1'b0;
		emit    = '0;
		emit.tag = rd_tag;
		emit.tcp = w_q;
		cmd     = '0;
		cmd.tag = tag_q;
		cmd.idx = {w_q, ws};
		case (state_q)
			sro_pkg::ST_DEC, sro_pkg::ST_INS: begin
				alu_a   = seq_q;
				alu_b   = ~exp_q[w_q];
				alu_cin = 1'b1;
				if (state_q == sro_pkg::ST_DEC) begin
					emit.tag = tag_q;
					emit.seq = seq_q;
					if (op_q == sro_pkg::OP_TICK) begin
						emit.valid = 1'b0;
					end else if (bypass) begin
						emit.valid = 1'b1;
						emit.tcp   = (cls_q == sro_pkg::CLS_TCP);
						emit.cause = sro_pkg::CAUSE_BYPASS;
					end else if (sum[sro_pkg::SEQ_W-1]) begin
						emit.valid = 1'b1;
						emit.cause = sro_pkg::CAUSE_OLD;
					end
				end else begin
					rd_pos  = pos_ins;
					cmd.idx = {w_q, pos_ins};
					cmd.set = 1'b1;
				end
			end
			sro_pkg::ST_ADV: begin
				alu_a      = adv_seq_q;
				alu_cin    = 1'b1;
				emit.valid = rd_valid;
				emit.seq   = adv_seq_q;
				emit.cause = sro_pkg::CAUSE_ADV;
				cmd.clr    = rd_valid;
			end
			sro_pkg::ST_REL: begin
				alu_a      = exp_q[w_q];
				alu_cin    = 1'b1;
				emit.valid = rd_valid;
				emit.seq   = exp_q[w_q];
				emit.cause = sro_pkg::CAUSE_INORDER;
				cmd.clr    = rd_valid;
			end
			sro_pkg::ST_FCHK: begin
				alu_a   = {{(sro_pkg::SEQ_W-sro_pkg::TIME_W){1'b0}}, now_q};
				alu_b   = {{(sro_pkg::SEQ_W-sro_pkg::TIME_W){1'b0}}, ~stamp_q[w_q]};
				alu_cin = 1'b1;
			end
			sro_pkg::ST_FLOOP: begin
				alu_a      = exp_q[w_q];
				alu_b      = {{(sro_pkg::SEQ_W-SW){1'b0}}, cnt_q};
				rd_pos     = pos_fl;
				cmd.idx    = {w_q, pos_fl};
				emit.valid = rd_valid;
				emit.seq   = sum;
				emit.cause = sro_pkg::CAUSE_FLUSH;
				cmd.clr    = rd_valid;
			end
			sro_pkg::ST_FEND: begin
				alu_a        = last_seq_q;
				alu_cin      = 1'b1;
				cmd.wipe     = 1'b1;
				cmd.wipe_win = w_q;
			end
			sro_pkg::ST_FIN: fin = 1'b1;
			default: ;
		endcase
		if (cfg_wipe) begin
			cmd.wipe     = 1'b1;
			cmd.wipe_win = cfg_idx[0];
		end
		// hold while a result cannot be taken
		go = (emit.valid || fin) ? stat.can : 1'b1;
		if (!go) begin
			cmd.set = 1'b0;
			cmd.clr = 1'b0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sro_pkg::ST_IDLE: if (s_tvalid) state_d = sro_pkg::ST_DEC;
			sro_pkg::ST_DEC: begin
				if (op_q == sro_pkg::OP_TICK) state_d = sro_pkg::ST_FCHK;
				else if (bypass) state_d = sro_pkg::ST_FIN;
				else if (sum[sro_pkg::SEQ_W-1]) state_d = sro_pkg::ST_UPD;
				else if (far) state_d = sro_pkg::ST_ADV;
				else state_d = sro_pkg::ST_INS;
			end
			sro_pkg::ST_ADV: if (cnt_q == SW'(1)) state_d = sro_pkg::ST_INS;
			sro_pkg::ST_INS: state_d = sro_pkg::ST_REL;
			sro_pkg::ST_REL: if (!rd_valid) state_d = sro_pkg::ST_UPD;
			sro_pkg::ST_UPD: state_d = sro_pkg::ST_FIN;
			sro_pkg::ST_FCHK: begin
				if (fire) state_d = sro_pkg::ST_FLOOP;
				else if (w_q) state_d = sro_pkg::ST_FIN;
			end
			sro_pkg::ST_FLOOP: if (fl_done) state_d = sro_pkg::ST_FEND;
			sro_pkg::ST_FEND: state_d = w_q ? sro_pkg::ST_FIN : sro_pkg::ST_FCHK;
			sro_pkg::ST_FIN: state_d = sro_pkg::ST_IDLE;
			default: state_d = sro_pkg::ST_IDLE;
		endcase
		if (!go) state_d = state_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sro_pkg::ST_IDLE;
			for (int i = 0; i < 2; i++) begin
				lg_q[i]    <= '0;
				tmo_q[i]   <= '0;
				exp_q[i]   <= '0;
				ws_q[i]    <= '0;
				held_q[i]  <= '0;
				armed_q[i] <= 1'b0;
				stamp_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					sro_pkg::CFG_UDP_WIN, sro_pkg::CFG_TCP_WIN: begin
						lg_q[cfg_idx[0]]    <= cfg_data[2:0];
						exp_q[cfg_idx[0]]   <= '0;
						ws_q[cfg_idx[0]]    <= '0;
						held_q[cfg_idx[0]]  <= '0;
						armed_q[cfg_idx[0]] <= 1'b0;
						stamp_q[cfg_idx[0]] <= '0;
					end
					sro_pkg::CFG_UDP_TMO: tmo_q[0] <= cfg_data;
					sro_pkg::CFG_TCP_TMO: tmo_q[1] <= cfg_data;
					default: ;
				endcase
			end
			if (go) begin
				case (state_q)
					sro_pkg::ST_ADV: begin
						if (rd_valid) held_q[w_q] <= held_q[w_q] - SW'(1);
						ws_q[w_q] <= ws_inc;
						if (cnt_q == SW'(1)) exp_q[w_q] <= cap_q ? seq_q : sum;
					end
					sro_pkg::ST_INS: if (!rd_valid) held_q[w_q] <= held_q[w_q] + SW'(1);
					sro_pkg::ST_REL: begin
						if (rd_valid) begin
							held_q[w_q] <= held_q[w_q] - SW'(1);
							ws_q[w_q]   <= ws_inc;
							exp_q[w_q]  <= sum;
						end
					end
					sro_pkg::ST_UPD: begin
						if (held_q[w_q] == '0) begin
							armed_q[w_q] <= 1'b0;
						end else if (rel_q || was_empty_q) begin
							armed_q[w_q] <= 1'b1;
							stamp_q[w_q] <= now_q;
						end
					end
					sro_pkg::ST_FLOOP: if (rd_valid) held_q[w_q] <= held_q[w_q] - SW'(1);
					sro_pkg::ST_FEND: begin
						exp_q[w_q]   <= sum;
						ws_q[w_q]    <= '0;
						held_q[w_q]  <= '0;
						armed_q[w_q] <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		if (state_q == sro_pkg::ST_IDLE && s_tvalid) begin
			op_q  <= s_tuser[0];
			cls_q <= s_tuser[2:1];
			w_q   <= s_tuser[1];
			seq_q <= s_tdata[31:0];
			tag_q <= s_tdata[32 +: sro_pkg::TAG_BITS];
			now_q <= s_tdata[63:48];
		end
		if (go) begin
			case (state_q)
				sro_pkg::ST_DEC: begin
					if (op_q == sro_pkg::OP_TICK) w_q <= 1'b0;
					was_empty_q <= held_q[w_q] == '0;
					rel_q       <= 1'b0;
					cap_q       <= cap;
					cnt_q       <= steps;
					adv_seq_q   <= exp_q[w_q];
				end
				sro_pkg::ST_ADV: begin
					adv_seq_q <= sum;
					cnt_q     <= cnt_q - SW'(1);
					if (rd_valid) rel_q <= 1'b1;
				end
				sro_pkg::ST_REL: if (rd_valid) rel_q <= 1'b1;
				sro_pkg::ST_FCHK: begin
					cnt_q <= '0;
					if (!fire) w_q <= 1'b1;
				end
				sro_pkg::ST_FLOOP: begin
					cnt_q <= k_inc;
					if (rd_valid) last_seq_q <= sum;
				end
				sro_pkg::ST_FEND: w_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// nothing may be left pending once the sequencer is back to idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sro_pkg::ST_IDLE |-> !stat.pend)
		else $error("pending result left behind at idle");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q[0] <= SW'(sro_pkg::DEPTH) && held_q[1] <= SW'(sro_pkg::DEPTH))
		else $error("held count beyond ring depth");

	// a beat with tlast is only produced by the final step of an item
	a_last_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && m_tlast |-> $past(state_q) == sro_pkg::ST_FIN)
		else $error("tlast raised outside the finish step");

endmodule
